// File: sv/bdt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bdt_pkg;

    // Symbol buffer: at most a shift frame plus a character frame
    localparam int PATTERN_W = 16;
    localparam int COUNT_W   = 5;
    localparam int CODE_W    = 5;
    localparam int FRAME_W   = 8;

    // Shift codes
    localparam logic [CODE_W-1:0] LTRS_CODE = 5'h1f;
    localparam logic [CODE_W-1:0] FIGS_CODE = 5'h1b;

    // Commands
    localparam logic CMD_BEGIN  = 1'b0;
    localparam logic CMD_ENCODE = 1'b1;

    // Symbol counts per item
    localparam logic [COUNT_W-1:0] CNT_NONE   = 5'd0;
    localparam logic [COUNT_W-1:0] CNT_FRAME  = 5'd8;
    localparam logic [COUNT_W-1:0] CNT_BEGIN  = 5'd11;
    localparam logic [COUNT_W-1:0] CNT_DOUBLE = 5'd16;

    typedef struct packed {
        logic              hit;
        logic [CODE_W-1:0] code;
    } lookup_t;

    // Symbols for one item, MSB first, plus the shift state it leaves
    typedef struct packed {
        logic [PATTERN_W-1:0] bits;
        logic [COUNT_W-1:0]   count;
        logic                 fig_shift;
    } plan_t;

    // Start bit, five code bits MSB first, two stop bits
    function automatic logic [FRAME_W-1:0] make_frame(input logic [CODE_W-1:0] code);
        make_frame = {1'b0, code, 2'b11};
    endfunction

    // Letters table, searched by character
    function automatic lookup_t letters_lookup(input logic [7:0] ch);
        lookup_t r;
        r.hit = 1'b1;
        case (ch)
            8'h54: r.code = 5'd1;   // T
            8'h0d: r.code = 5'd2;   // CR
            8'h4f: r.code = 5'd3;   // O
            8'h20: r.code = 5'd4;   // space
            8'h48: r.code = 5'd5;   // H
            8'h4e: r.code = 5'd6;   // N
            8'h4d: r.code = 5'd7;   // M
            8'h0a: r.code = 5'd8;   // LF
            8'h4c: r.code = 5'd9;   // L
            8'h52: r.code = 5'd10;  // R
            8'h47: r.code = 5'd11;  // G
            8'h49: r.code = 5'd12;  // I
            8'h50: r.code = 5'd13;  // P
            8'h43: r.code = 5'd14;  // C
            8'h56: r.code = 5'd15;  // V
            8'h45: r.code = 5'd16;  // E
            8'h5a: r.code = 5'd17;  // Z
            8'h44: r.code = 5'd18;  // D
            8'h42: r.code = 5'd19;  // B
            8'h53: r.code = 5'd20;  // S
            8'h59: r.code = 5'd21;  // Y
            8'h46: r.code = 5'd22;  // F
            8'h58: r.code = 5'd23;  // X
            8'h41: r.code = 5'd24;  // A
            8'h57: r.code = 5'd25;  // W
            8'h4a: r.code = 5'd26;  // J
            8'h55: r.code = 5'd28;  // U
            8'h51: r.code = 5'd29;  // Q
            8'h4b: r.code = 5'd30;  // K
            default:
            begin
                r.hit  = 1'b0;
                r.code = 5'd0;
            end
        endcase
        return r;
    endfunction

    // Figures table, searched by character
    function automatic lookup_t figures_lookup(input logic [7:0] ch);
        lookup_t r;
        r.hit = 1'b1;
        case (ch)
            8'h35: r.code = 5'd1;   // 5
            8'h0d: r.code = 5'd2;   // CR
            8'h39: r.code = 5'd3;   // 9
            8'h20: r.code = 5'd4;   // space
            8'h2c: r.code = 5'd6;   // ,
            8'h2e: r.code = 5'd7;   // .
            8'h0a: r.code = 5'd8;   // LF
            8'h29: r.code = 5'd9;   // )
            8'h34: r.code = 5'd10;  // 4
            8'h26: r.code = 5'd11;  // &
            8'h38: r.code = 5'd12;  // 8
            8'h30: r.code = 5'd13;  // 0
            8'h3a: r.code = 5'd14;  // :
            8'h3b: r.code = 5'd15;  // ;
            8'h33: r.code = 5'd16;  // 3
            8'h22: r.code = 5'd17;  // double quote
            8'h24: r.code = 5'd18;  // $
            8'h3f: r.code = 5'd19;  // ?
            8'h36: r.code = 5'd21;  // 6
            8'h21: r.code = 5'd22;  // !
            8'h2f: r.code = 5'd23;  // /
            8'h2d: r.code = 5'd24;  // -
            8'h32: r.code = 5'd25;  // 2
            8'h27: r.code = 5'd26;  // apostrophe
            8'h37: r.code = 5'd28;  // 7
            8'h31: r.code = 5'd29;  // 1
            8'h28: r.code = 5'd30;  // (
            default:
            begin
                r.hit  = 1'b0;
                r.code = 5'd0;
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: sv/bdt_plan.sv
`timescale 1ns / 1ps
`default_nettype none

// Builds the symbol sequence for one item from the shift state
module bdt_plan
    import bdt_pkg::*;
(
    input  wire logic       command,
    input  wire logic [7:0] character,
    input  wire logic       fig_shift,
    output plan_t           plan
);

    lookup_t ltr;
    lookup_t fig;

    assign ltr = letters_lookup(character);
    assign fig = figures_lookup(character);

    always_comb
    begin
        plan.bits      = '0;
        plan.count     = CNT_NONE;
        plan.fig_shift = fig_shift;
        if (command == CMD_BEGIN)
        begin
            // three marks, then letters shift
            plan.bits      = {3'b111, make_frame(LTRS_CODE), 5'b00000};
            plan.count     = CNT_BEGIN;
            plan.fig_shift = 1'b0;
        end
        else if (ltr.hit && fig.hit && (ltr.code == fig.code))
        begin
            // shared character: no shift
            plan.bits  = {make_frame(ltr.code), 8'h00};
            plan.count = CNT_FRAME;
        end
        else if (ltr.hit)
        begin
            plan.fig_shift = 1'b0;
            if (fig_shift)
            begin
                plan.bits  = {make_frame(LTRS_CODE), make_frame(ltr.code)};
                plan.count = CNT_DOUBLE;
            end
            else
            begin
                plan.bits  = {make_frame(ltr.code), 8'h00};
                plan.count = CNT_FRAME;
            end
        end
        else if (fig.hit)
        begin
            plan.fig_shift = 1'b1;
            if (!fig_shift)
            begin
                plan.bits  = {make_frame(FIGS_CODE), make_frame(fig.code)};
                plan.count = CNT_DOUBLE;
            end
            else
            begin
                plan.bits  = {make_frame(fig.code), 8'h00};
                plan.count = CNT_FRAME;
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/baudot_rtty_symbol_encoder.sv
// An accepted item goes through the pending register, then the output register.
// Throughput: one symbol per cycle while sym_ready is high; an item is 8, 11
// or 16 symbols long, and an unrecognized character gives none.
// A pending register holds the next item's symbols while the current one drains.
// Reset (rst_n low, asynchronous) empties both registers and selects letters.
`timescale 1ns / 1ps
`default_nettype none

module baudot_rtty_symbol_encoder
    import bdt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       char_valid,
    output logic            char_ready,
    input  wire logic       command,
    input  wire logic [7:0] character,
    output logic            sym_valid,
    input  wire logic       sym_ready,
    output logic            symbol,
    output logic            last
);

    logic                 fig_shift_reg;
    logic                 pend_valid_reg;
    logic [PATTERN_W-1:0] pend_bits_reg;
    logic [COUNT_W-1:0]   pend_count_reg;
    logic                 out_valid_reg;
    logic [PATTERN_W-1:0] out_bits_reg;
    logic [COUNT_W-1:0]   out_count_reg;

    plan_t plan;
    logic  out_done;
    logic  out_free;
    logic  pend_move;
    logic  in_fire;

    bdt_plan u_plan (
        .command   (command),
        .character (character),
        .fig_shift (fig_shift_reg),
        .plan      (plan)
    );

    // Handshake control
    assign out_done   = out_valid_reg && sym_ready && (out_count_reg == 5'd1);
    assign out_free   = !out_valid_reg || out_done;
    assign pend_move  = pend_valid_reg && out_free;
    assign char_ready = !pend_valid_reg || out_free;
    assign in_fire    = char_valid && char_ready;

    assign sym_valid = out_valid_reg;
    assign symbol    = out_bits_reg[PATTERN_W-1];
    assign last      = (out_count_reg == 5'd1);

    // Shift state and pending item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fig_shift_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_count_reg <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                fig_shift_reg <= plan.fig_shift;
            end
            if (in_fire && (plan.count != CNT_NONE))
            begin
                pend_valid_reg <= 1'b1;
                pend_count_reg <= plan.count;
            end
            else if (pend_move)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && (plan.count != CNT_NONE))
        begin
            pend_bits_reg <= plan.bits;
        end
    end

    // Output shift register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_count_reg <= '0;
        end
        else if (pend_move)
        begin
            out_valid_reg <= 1'b1;
            out_count_reg <= pend_count_reg;
        end
        else if (out_valid_reg && sym_ready)
        begin
            if (out_count_reg == 5'd1)
            begin
                out_valid_reg <= 1'b0;
            end
            out_count_reg <= out_count_reg - 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_move)
        begin
            out_bits_reg <= pend_bits_reg;
        end
        else if (out_valid_reg && sym_ready)
        begin
            out_bits_reg <= {out_bits_reg[PATTERN_W-2:0], 1'b0};
        end
    end

endmodule

`default_nettype wire

// File: sv/bdt_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module bdt_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       char_valid,
    input wire logic       char_ready,
    input wire logic       command,
    input wire logic [7:0] character,
    input wire logic       sym_valid,
    input wire logic       sym_ready,
    input wire logic       symbol,
    input wire logic       last
);

    // Stalled symbol holds
    a_sym_hold: assert property (@(posedge clk) disable iff (!rst_n)
        sym_valid && !sym_ready |=> sym_valid && $stable(symbol) && $stable(last))
        else $error("stalled symbol changed");

    // Every item ends on a stop bit
    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        sym_valid && last |-> symbol)
        else $error("final symbol is not a mark");

    // Symbols of one item stream without gaps
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        sym_valid && sym_ready && !last |=> sym_valid)
        else $error("gap inside an item");

    // Nothing comes out right after reset without an item
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !sym_valid)
        else $error("symbol right after reset");

endmodule

bind baudot_rtty_symbol_encoder bdt_checker u_bdt_checker (.*);

`default_nettype wire

// File: tb/baudot_rtty_symbol_encoder_tb.sv
`timescale 1ns / 1ps

module baudot_rtty_symbol_encoder_tb;
    import bdt_pkg::*;

    // One symbol item as seen on the output channel
    typedef struct packed {
        logic symbol;
        logic last;
    } rtty_symbol_t;

    // Tracks the letters/figures shift and the symbols still owed by the block
    class rtty_line_tracker;
        logic [7:0]   letters_tab [32];
        logic [7:0]   figures_tab [32];
        logic         figures_mode;
        rtty_symbol_t symbol_queue[$];
        int           mismatches;

        function new();
            // 8'h00 marks an empty slot
            letters_tab = '{8'h00, 8'h54, 8'h0d, 8'h4f, 8'h20, 8'h48, 8'h4e, 8'h4d,
                            8'h0a, 8'h4c, 8'h52, 8'h47, 8'h49, 8'h50, 8'h43, 8'h56,
                            8'h45, 8'h5a, 8'h44, 8'h42, 8'h53, 8'h59, 8'h46, 8'h58,
                            8'h41, 8'h57, 8'h4a, 8'h00, 8'h55, 8'h51, 8'h4b, 8'h00};
            figures_tab = '{8'h00, 8'h35, 8'h0d, 8'h39, 8'h20, 8'h00, 8'h2c, 8'h2e,
                            8'h0a, 8'h29, 8'h34, 8'h26, 8'h38, 8'h30, 8'h3a, 8'h3b,
                            8'h33, 8'h22, 8'h24, 8'h3f, 8'h00, 8'h36, 8'h21, 8'h2f,
                            8'h2d, 8'h32, 8'h27, 8'h00, 8'h37, 8'h31, 8'h28, 8'h00};
            figures_mode = 1'b0;
            mismatches   = 0;
        endfunction

        // Baudot code of a character, -1 when absent; NUL never matches
        function int find_code(input logic use_figures, input logic [7:0] ch);
            if (ch == 8'h00)
                return -1;
            for (int i = 0; i < 32; i++)
            begin
                if ((use_figures ? figures_tab[i] : letters_tab[i]) == ch)
                    return i;
            end
            return -1;
        endfunction

        // Any character that sits in one of the tables
        function logic [7:0] random_known_char();
            logic [7:0] ch;
            ch = 8'h00;
            while (ch == 8'h00)
            begin
                if ($urandom_range(0, 1) == 1)
                    ch = figures_tab[$urandom_range(0, 31)];
                else
                    ch = letters_tab[$urandom_range(0, 31)];
            end
            return ch;
        endfunction

        function void push_symbol(input logic s);
            symbol_queue.push_back(rtty_symbol_t'{s, 1'b0});
        endfunction

        // Space start bit, code MSB first, two mark stop bits
        function void push_frame(input logic [CODE_W-1:0] code);
            push_symbol(1'b0);
            for (int b = CODE_W - 1; b >= 0; b--)
                push_symbol(code[b]);
            push_symbol(1'b1);
            push_symbol(1'b1);
        endfunction

        // Note an accepted item and queue the symbols it must produce
        function void accept_char(input logic cmd, input logic [7:0] ch);
            int           prior_size;
            int           li;
            int           fi;
            rtty_symbol_t tail;
            prior_size = symbol_queue.size();
            if (cmd == CMD_BEGIN)
            begin
                push_symbol(1'b1);
                push_symbol(1'b1);
                push_symbol(1'b1);
                push_frame(LTRS_CODE);
                figures_mode = 1'b0;
            end
            else
            begin
                li = find_code(1'b0, ch);
                fi = find_code(1'b1, ch);
                if (li < 0 && fi < 0)
                begin
                    // unrecognized: no symbols
                end
                else if (li == fi)
                    push_frame(CODE_W'(li));
                else if (li >= 0)
                begin
                    if (figures_mode)
                    begin
                        push_frame(LTRS_CODE);
                        figures_mode = 1'b0;
                    end
                    push_frame(CODE_W'(li));
                end
                else
                begin
                    if (!figures_mode)
                    begin
                        push_frame(FIGS_CODE);
                        figures_mode = 1'b1;
                    end
                    push_frame(CODE_W'(fi));
                end
            end
            // flag the final symbol of this item
            if (symbol_queue.size() > prior_size)
            begin
                tail      = symbol_queue.pop_back();
                tail.last = 1'b1;
                symbol_queue.push_back(tail);
            end
        endfunction

        // Compare one output item against the oldest owed symbol
        function void compare_symbol(input logic sym, input logic lst);
            rtty_symbol_t want;
            if (symbol_queue.size() == 0)
            begin
                $error("unexpected symbol item: symbol=%0d last=%0d", sym, lst);
                mismatches++;
                return;
            end
            want = symbol_queue.pop_front();
            if (sym !== want.symbol)
            begin
                $error("symbol: expected %0d, got %0d", want.symbol, sym);
                mismatches++;
            end
            if (lst !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, lst);
                mismatches++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       char_valid;
    logic       char_ready;
    logic       command;
    logic [7:0] character;
    logic       sym_valid;
    logic       sym_ready;
    logic       symbol;
    logic       last;

    rtty_line_tracker tracker;

    bit hold_request;
    bit no_gaps;
    bit quiet_tail;

    baudot_rtty_symbol_encoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .command    (command),
        .character  (character),
        .sym_valid  (sym_valid),
        .sym_ready  (sym_ready),
        .symbol     (symbol),
        .last       (last)
    );

    // 100 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one item and hold it until the block takes it
    task automatic send_char(input logic cmd, input logic [7:0] ch);
        char_valid <= 1'b1;
        command    <= cmd;
        character  <= ch;
        do
            @(posedge clk);
        while (!char_ready);
        tracker.accept_char(cmd, ch);
    endtask

    // Send, then maybe drop valid for a random burst
    task automatic offer_char(input logic cmd, input logic [7:0] ch);
        int gap;
        send_char(cmd, ch);
        if (!no_gaps && !quiet_tail && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 15);
            char_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop offering and wait for every owed symbol
    task automatic wait_drained();
        char_valid <= 1'b0;
        while (tracker.symbol_queue.size() != 0)
            @(posedge clk);
    endtask

    // Output side: check accepted symbols, stall in bursts
    initial
    begin : symbol_sink
        int stall_left;
        stall_left = 0;
        sym_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (sym_valid === 1'b1 && sym_ready === 1'b1)
                tracker.compare_symbol(symbol, last);
            if (stall_left > 0)
            begin
                stall_left--;
                sym_ready <= 1'b0;
            end
            else if (hold_request)
            begin
                // long hold-off so the block backs up into its input
                hold_request = 1'b0;
                stall_left   = 399;
                sym_ready <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 15) - 1;
                sym_ready <= 1'b0;
            end
            else
                sym_ready <= 1'b1;
        end
    end

    // Input side: reset, directed items, random items, drain
    initial
    begin : char_source
        int         pick;
        logic [7:0] ch;
        tracker      = new();
        hold_request = 1'b0;
        no_gaps      = 1'b0;
        quiet_tail   = 1'b0;
        rst_n      <= 1'b0;
        char_valid <= 1'b0;
        command    <= CMD_BEGIN;
        character  <= 8'h00;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: preamble, shifts both ways, shared codes, rejects
        offer_char(CMD_BEGIN,  8'hff);  // character ignored on begin
        offer_char(CMD_ENCODE, 8'h41);  // A, letters already
        offer_char(CMD_ENCODE, 8'h00);  // NUL rejected
        offer_char(CMD_ENCODE, 8'h35);  // 5, needs figures shift
        offer_char(CMD_ENCODE, 8'h31);  // 1, already figures
        offer_char(CMD_ENCODE, 8'h20);  // space, shared code
        offer_char(CMD_ENCODE, 8'h0d);  // CR, shared code
        offer_char(CMD_ENCODE, 8'h0a);  // LF, shared code
        offer_char(CMD_ENCODE, 8'h48);  // H, back to letters
        offer_char(CMD_ENCODE, 8'h61);  // lowercase rejected
        offer_char(CMD_ENCODE, 8'h80);  // high codes rejected
        offer_char(CMD_ENCODE, 8'hff);
        offer_char(CMD_ENCODE, 8'h28);  // (, top figures code
        offer_char(CMD_BEGIN,  8'h00);  // begin while in figures
        offer_char(CMD_ENCODE, 8'h4b);  // K, top letters code
        offer_char(CMD_ENCODE, 8'h54);  // T, lowest code
        offer_char(CMD_ENCODE, 8'h3f);  // ?
        offer_char(CMD_ENCODE, 8'h53);  // S, empty figures slot
        offer_char(CMD_ENCODE, 8'h57);  // W
        offer_char(CMD_BEGIN,  8'h55);
        offer_char(CMD_ENCODE, 8'h51);  // Q
        offer_char(CMD_ENCODE, 8'h37);  // 7

        // random: mostly known characters, some begins, some noise
        for (int i = 0; i < 98; i++)
        begin
            if (i == 30)
            begin
                hold_request = 1'b1;
                no_gaps      = 1'b1;
            end
            if (i == 45)
                no_gaps = 1'b0;
            if (i == 60)
                wait_drained();
            if (i == 75)
                quiet_tail = 1'b1;
            pick = $urandom_range(0, 9);
            if (pick == 0)
                offer_char(CMD_BEGIN, 8'($urandom_range(0, 255)));
            else if (pick <= 7)
                offer_char(CMD_ENCODE, tracker.random_known_char());
            else
            begin
                ch = 8'($urandom_range(0, 255));
                offer_char(CMD_ENCODE, ch);
            end
        end
        char_valid <= 1'b0;

        // let every owed symbol arrive, then watch for strays
        wait_drained();
        repeat (40) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.symbol_queue.size() == 0)
            $display("** baudot_rtty_symbol_encoder: PASSED **");
        else
            $display("** baudot_rtty_symbol_encoder: FAILED **");
        $finish;
    end

    // Watchdog
    initial
    begin
        #3_000_000;
        $display("** baudot_rtty_symbol_encoder: FAILED **");
        $finish;
    end

endmodule
